FILE: rtl/core/spq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package spq_pkg;

    localparam int PRIO_W    = 16;
    localparam int PAYLOAD_W = 32;
    localparam int OCC_W     = 4;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef enum logic {
        REQ_ENQ = 1'b0,
        REQ_DEQ = 1'b1
    } req_type_t;

    typedef struct packed {
        req_type_t                     req_type;
        logic signed [PRIO_W-1:0]      prio;
        logic signed [PAYLOAD_W-1:0]   payload;
    } op_t;

    typedef struct packed {
        logic                          full;
        logic                          empty;
        logic signed [PRIO_W-1:0]      head_prio;
        logic signed [PAYLOAD_W-1:0]   head_payload;
    } q_state_t;

endpackage

`default_nettype wire

FILE: rtl/core/spq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface spq_req_if;

    logic                                     valid;
    logic                                     ready;
    logic                                     req_type;
    logic signed [spq_pkg::PRIO_W-1:0]        prio_in;
    logic signed [spq_pkg::PAYLOAD_W-1:0]     payload_in;

    modport source (output valid, output req_type, output prio_in, output payload_in,
                    input ready);
    modport sink   (input valid, input req_type, input prio_in, input payload_in,
                    output ready);

endinterface

`default_nettype wire

FILE: rtl/core/spq_rsp_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface spq_rsp_if;

    logic                                     valid;
    logic                                     ready;
    spq_pkg::status_t                         status;
    logic signed [spq_pkg::PRIO_W-1:0]        prio_out;
    logic signed [spq_pkg::PAYLOAD_W-1:0]     payload_out;
    logic [spq_pkg::OCC_W-1:0]                occupancy;

    modport source (output valid, output status, output prio_out, output payload_out,
                    output occupancy, input ready);
    modport sink   (input valid, input status, input prio_out, input payload_out,
                    input occupancy, output ready);

endinterface

`default_nettype wire

FILE: rtl/core/spq_in_stage.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_in_stage
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    spq_req_if.sink          req,
    input  wire logic        adv,
    output logic             vld,
    output spq_pkg::op_t     op
);

    logic          vld_reg;
    logic          vld_next;
    spq_pkg::op_t  op_reg;
    logic          take;

    assign req.ready = !vld_reg || adv;
    assign take      = req.valid && req.ready;

    always_comb
    begin
        vld_next = vld_reg;
        if (take)
        begin
            vld_next = 1'b1;
        end
        else if (adv)
        begin
            vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            op_reg.req_type <= spq_pkg::req_type_t'(req.req_type);
            op_reg.prio     <= req.prio_in;
            op_reg.payload  <= req.payload_in;
        end
    end

    assign vld = vld_reg;
    assign op  = op_reg;

endmodule

`default_nettype wire

FILE: rtl/core/spq_entry_array.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_entry_array
#(
    parameter int DEPTH = 8,
    parameter int CW    = $clog2(DEPTH + 1)
)
(
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           fire,
    input  wire spq_pkg::op_t   op,
    output spq_pkg::q_state_t   st,
    output logic [CW-1:0]       count_next
);

    logic signed [spq_pkg::PRIO_W-1:0]    prio_reg    [DEPTH];
    logic signed [spq_pkg::PAYLOAD_W-1:0] payload_reg [DEPTH];
    logic signed [spq_pkg::PRIO_W-1:0]    prio_next    [DEPTH];
    logic signed [spq_pkg::PAYLOAD_W-1:0] payload_next [DEPTH];
    logic [CW-1:0]                        count_reg;
    logic [DEPTH-1:0]                     lt;
    logic                                 full;
    logic                                 empty;

    assign full  = (count_reg == CW'(DEPTH));
    assign empty = (count_reg == '0);

    // entries below the new item in priority, a suffix of the held entries
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            lt[i] = (int'(count_reg) > i) && (prio_reg[i] < op.prio);
        end
    end

    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            prio_next[i]    = prio_reg[i];
            payload_next[i] = payload_reg[i];
            if (op.req_type == spq_pkg::REQ_ENQ)
            begin
                if (!full)
                begin
                    if (i > 0 && lt[(i > 0) ? i - 1 : 0])
                    begin
                        prio_next[i]    = prio_reg[(i > 0) ? i - 1 : 0];
                        payload_next[i] = payload_reg[(i > 0) ? i - 1 : 0];
                    end
                    else if (lt[i] || int'(count_reg) == i)
                    begin
                        prio_next[i]    = op.prio;
                        payload_next[i] = op.payload;
                    end
                end
            end
            else if (i < DEPTH - 1)
            begin
                prio_next[i]    = prio_reg[(i < DEPTH - 1) ? i + 1 : i];
                payload_next[i] = payload_reg[(i < DEPTH - 1) ? i + 1 : i];
            end
        end
    end

    always_comb
    begin
        count_next = count_reg;
        if (op.req_type == spq_pkg::REQ_ENQ)
        begin
            if (!full)
            begin
                count_next = count_reg + CW'(1);
            end
        end
        else if (!empty)
        begin
            count_next = count_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (fire)
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (fire)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                prio_reg[i]    <= prio_next[i];
                payload_reg[i] <= payload_next[i];
            end
        end
    end

    assign st.full         = full;
    assign st.empty        = empty;
    assign st.head_prio    = prio_reg[0];
    assign st.head_payload = payload_reg[0];

endmodule

`default_nettype wire

FILE: rtl/core/sorted_priority_queue_unit.sv
`timescale 1ns / 1ps
// a request passes the input register, then the result register, before its result is valid
// throughput: one request per cycle while results are taken
// entries shift in parallel, so an insert or a remove updates all slots together
// reset: rst_n asynchronous active low empties the queue and both registers
// entry storage is not cleared, only slots below the entry count are read
`default_nettype none

module sorted_priority_queue_unit
#(
    parameter int DEPTH = 8
)
(
    input  wire logic   clk,
    input  wire logic   rst_n,
    spq_req_if.sink     req,
    spq_rsp_if.source   rsp
);

    localparam int CW = $clog2(DEPTH + 1);

    logic                                 op_vld;
    spq_pkg::op_t                         op;
    logic                                 adv;
    spq_pkg::q_state_t                    st;
    logic [CW-1:0]                        count_next;

    logic                                 rsp_vld_reg;
    logic                                 rsp_vld_next;
    spq_pkg::status_t                     status_reg;
    spq_pkg::status_t                     status_next;
    logic signed [spq_pkg::PRIO_W-1:0]    prio_out_reg;
    logic signed [spq_pkg::PRIO_W-1:0]    prio_out_next;
    logic signed [spq_pkg::PAYLOAD_W-1:0] payload_out_reg;
    logic signed [spq_pkg::PAYLOAD_W-1:0] payload_out_next;
    logic [spq_pkg::OCC_W-1:0]            occ_reg;

    assign adv = op_vld && (!rsp_vld_reg || rsp.ready);

    spq_in_stage u_in_stage
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req),
        .adv   (adv),
        .vld   (op_vld),
        .op    (op)
    );

    spq_entry_array #(.DEPTH(DEPTH), .CW(CW)) u_entry_array
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (adv),
        .op         (op),
        .st         (st),
        .count_next (count_next)
    );

    always_comb
    begin
        status_next      = spq_pkg::ST_OK;
        prio_out_next    = '0;
        payload_out_next = '0;
        if (op.req_type == spq_pkg::REQ_ENQ)
        begin
            if (st.full)
            begin
                status_next = spq_pkg::ST_FULL;
            end
        end
        else if (st.empty)
        begin
            status_next = spq_pkg::ST_EMPTY;
        end
        else
        begin
            prio_out_next    = st.head_prio;
            payload_out_next = st.head_payload;
        end
    end

    always_comb
    begin
        rsp_vld_next = rsp_vld_reg;
        if (adv)
        begin
            rsp_vld_next = 1'b1;
        end
        else if (rsp.ready)
        begin
            rsp_vld_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_vld_reg <= 1'b0;
        end
        else
        begin
            rsp_vld_reg <= rsp_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            status_reg      <= status_next;
            prio_out_reg    <= prio_out_next;
            payload_out_reg <= payload_out_next;
            occ_reg         <= spq_pkg::OCC_W'(count_next);
        end
    end

    assign rsp.valid       = rsp_vld_reg;
    assign rsp.status      = status_reg;
    assign rsp.prio_out    = prio_out_reg;
    assign rsp.payload_out = payload_out_reg;
    assign rsp.occupancy   = occ_reg;

endmodule

`default_nettype wire

FILE: rtl/core/spq_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module spq_checker
#(
    parameter int DEPTH = 8
)
(
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  rsp_valid,
    input  wire logic                                  rsp_ready,
    input  wire spq_pkg::status_t                      status,
    input  wire logic signed [spq_pkg::PRIO_W-1:0]     prio_out,
    input  wire logic signed [spq_pkg::PAYLOAD_W-1:0]  payload_out,
    input  wire logic [spq_pkg::OCC_W-1:0]             occupancy
);

    a_full_no_data: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == spq_pkg::ST_FULL |-> prio_out == '0 && payload_out == '0)
        else $error("full result carries data");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == spq_pkg::ST_EMPTY
            |-> occupancy == '0 && prio_out == '0 && payload_out == '0)
        else $error("empty result with entries or data");

    a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && status == spq_pkg::ST_FULL |-> occupancy == spq_pkg::OCC_W'(DEPTH))
        else $error("full result with wrong occupancy");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(status) && $stable(occupancy))
        else $error("stalled result changed");

endmodule

bind sorted_priority_queue_unit spq_checker #(.DEPTH(DEPTH)) u_spq_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .rsp_valid   (rsp.valid),
    .rsp_ready   (rsp.ready),
    .status      (rsp.status),
    .prio_out    (rsp.prio_out),
    .payload_out (rsp.payload_out),
    .occupancy   (rsp.occupancy)
);

`default_nettype wire

FILE: tb/sv/tb_sorted_priority_queue_unit.sv
`timescale 1ns / 1ps

module tb_sorted_priority_queue_unit;

    localparam int DEPTH      = 8;
    localparam int CALM_TAIL  = 150;
    localparam int IDLE_LIMIT = 2000;
    localparam int SETTLE     = 8;

    typedef struct {
        spq_pkg::status_t                       status;
        logic signed [spq_pkg::PRIO_W-1:0]      prio;
        logic signed [spq_pkg::PAYLOAD_W-1:0]   payload;
        logic [spq_pkg::OCC_W-1:0]              occupancy;
    } rsp_t;

    logic clk;
    logic rst_n;

    spq_req_if req_if ();
    spq_rsp_if rsp_if ();

    sorted_priority_queue_unit #(
        .DEPTH (DEPTH)
    ) u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    // shadow copy of the sorted entries
    logic signed [spq_pkg::PRIO_W-1:0]    held_prio    [DEPTH];
    logic signed [spq_pkg::PAYLOAD_W-1:0] held_payload [DEPTH];
    int                                   held_count;

    spq_pkg::op_t request_plan  [$];
    rsp_t         due_responses [$];
    int           plan_total;
    int           requests_taken;
    int           mismatches;
    int           send_gap;
    int           stall_left;
    int           idle_cycles;

    function automatic rsp_t apply_request(spq_pkg::op_t op);
        rsp_t r;
        int   pos;
        r.status  = spq_pkg::ST_OK;
        r.prio    = '0;
        r.payload = '0;
        if (op.req_type == spq_pkg::REQ_ENQ)
        begin
            if (held_count >= DEPTH)
                r.status = spq_pkg::ST_FULL;
            else
            begin
                pos = held_count;
                while (pos > 0 && held_prio[pos-1] < $signed(op.prio))
                begin
                    held_prio[pos]    = held_prio[pos-1];
                    held_payload[pos] = held_payload[pos-1];
                    pos--;
                end
                held_prio[pos]    = op.prio;
                held_payload[pos] = op.payload;
                held_count++;
            end
        end
        else if (held_count == 0)
            r.status = spq_pkg::ST_EMPTY;
        else
        begin
            r.prio    = held_prio[0];
            r.payload = held_payload[0];
            for (int k = 0; k + 1 < held_count; k++)
            begin
                held_prio[k]    = held_prio[k+1];
                held_payload[k] = held_payload[k+1];
            end
            held_count--;
        end
        r.occupancy = held_count[spq_pkg::OCC_W-1:0];
        return r;
    endfunction

    task automatic add_request(spq_pkg::req_type_t t, logic signed [spq_pkg::PRIO_W-1:0] p,
                               logic signed [spq_pkg::PAYLOAD_W-1:0] d);
        spq_pkg::op_t op;
        op.req_type = t;
        op.prio     = p;
        op.payload  = d;
        request_plan.push_back(op);
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // request driver
    always @(posedge clk)
    begin
        spq_pkg::op_t taken;
        spq_pkg::op_t nxt;
        if (rst_n)
        begin
            if (req_if.valid && req_if.ready)
            begin
                taken.req_type = spq_pkg::req_type_t'(req_if.req_type);
                taken.prio     = req_if.prio_in;
                taken.payload  = req_if.payload_in;
                due_responses.push_back(apply_request(taken));
                requests_taken++;
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap > 0)
                begin
                    send_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (request_plan.size() != 0 && requests_taken + CALM_TAIL < plan_total
                         && $urandom_range(0, 9) == 0)
                begin
                    send_gap = $urandom_range(0, 14);
                    req_if.valid <= 1'b0;
                end
                else if (request_plan.size() != 0)
                begin
                    nxt = request_plan.pop_front();
                    req_if.valid      <= 1'b1;
                    req_if.req_type   <= nxt.req_type;
                    req_if.prio_in    <= nxt.prio;
                    req_if.payload_in <= nxt.payload;
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        rsp_t want;
        if (rst_n)
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                if (due_responses.size() == 0)
                begin
                    $error("unexpected item: status %0d prio_out %0d payload_out %h occupancy %0d",
                           rsp_if.status, rsp_if.prio_out, rsp_if.payload_out,
                           rsp_if.occupancy);
                    mismatches++;
                end
                else
                begin
                    want = due_responses.pop_front();
                    if (rsp_if.status !== want.status)
                    begin
                        $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
                        mismatches++;
                    end
                    if (rsp_if.prio_out !== want.prio)
                    begin
                        $error("prio_out: expected %0d, actual %0d", want.prio, rsp_if.prio_out);
                        mismatches++;
                    end
                    if (rsp_if.payload_out !== want.payload)
                    begin
                        $error("payload_out: expected %h, actual %h", want.payload,
                               rsp_if.payload_out);
                        mismatches++;
                    end
                    if (rsp_if.occupancy !== want.occupancy)
                    begin
                        $error("occupancy: expected %0d, actual %0d", want.occupancy,
                               rsp_if.occupancy);
                        mismatches++;
                    end
                end
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_if.ready <= 1'b0;
            end
            else if (requests_taken + CALM_TAIL < plan_total && $urandom_range(0, 9) == 0)
            begin
                stall_left = $urandom_range(0, 14);
                rsp_if.ready <= 1'b0;
            end
            else
                rsp_if.ready <= 1'b1;
        end
    end

    // watchdog on cycles with no handshake
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready))
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT)
            begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    initial
    begin
        int                                   enq_pct;
        int                                   sel;
        logic signed [spq_pkg::PRIO_W-1:0]    p;
        logic signed [spq_pkg::PAYLOAD_W-1:0] d;

        rst_n             = 1'b0;
        req_if.valid      = 1'b0;
        req_if.req_type   = spq_pkg::REQ_ENQ;
        req_if.prio_in    = '0;
        req_if.payload_in = '0;
        rsp_if.ready      = 1'b0;
        held_count        = 0;
        requests_taken    = 0;
        mismatches        = 0;
        send_gap          = 0;
        stall_left        = 0;
        idle_cycles       = 0;

        // empty, fill with extremes and ties, overflow, drain, empty again
        add_request(spq_pkg::REQ_DEQ, 16'sd0, 32'sd0);
        add_request(spq_pkg::REQ_ENQ, 16'sd3, 32'sd1);
        add_request(spq_pkg::REQ_ENQ, 16'sh7fff, 32'sh7fffffff);
        add_request(spq_pkg::REQ_ENQ, 16'sh8000, 32'sh80000000);
        add_request(spq_pkg::REQ_ENQ, 16'sd0, 32'sd0);
        add_request(spq_pkg::REQ_ENQ, 16'sd3, 32'sd2);
        add_request(spq_pkg::REQ_ENQ, -16'sd1, 32'shffffffff);
        add_request(spq_pkg::REQ_ENQ, 16'sd3, 32'sd3);
        add_request(spq_pkg::REQ_ENQ, 16'sd0, 32'sh5a5a5a5a);
        add_request(spq_pkg::REQ_ENQ, 16'sh7fff, 32'shdeadbeef);
        for (int k = 0; k < DEPTH; k++)
            add_request(spq_pkg::REQ_DEQ, 16'sh7fff, 32'shffffffff);
        add_request(spq_pkg::REQ_DEQ, 16'sh8000, 32'sh12345678);

        // runs biased to fill or drain, or balanced, so full and empty come up often
        for (int blk = 0; blk < 44; blk++)
        begin
            sel = $urandom_range(0, 2);
            enq_pct = (sel == 0) ? 25 : ((sel == 1) ? 50 : 80);
            for (int k = 0; k < 20; k++)
            begin
                sel = $urandom_range(0, 9);
                if (sel == 0)
                    p = 16'sh7fff;
                else if (sel == 1)
                    p = 16'sh8000;
                else if (sel < 6)
                    p = spq_pkg::PRIO_W'($urandom_range(0, 6)) - spq_pkg::PRIO_W'(3);
                else
                    p = spq_pkg::PRIO_W'($urandom());
                sel = $urandom_range(0, 15);
                if (sel == 0)
                    d = '1;
                else if (sel == 1)
                    d = '0;
                else
                    d = $urandom();
                add_request(($urandom_range(0, 99) < enq_pct) ? spq_pkg::REQ_ENQ
                                                              : spq_pkg::REQ_DEQ, p, d);
            end
        end
        plan_total = request_plan.size();

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        while (requests_taken < plan_total)
            @(posedge clk);
        while (due_responses.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);

        if (mismatches == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
